[rtl/swm_pkg.sv]
package swm_pkg;

    // Default sizing of the candidate queue and of the sample words.
    localparam int unsigned WINDOW_MAX_DEF   = 16;
    localparam int unsigned SAMPLE_WIDTH_DEF = 16;

    // Width of the window_size configuration register.
    localparam int unsigned CFG_W = 5;

endpackage

[rtl/swm_in_if.sv]
interface swm_in_if #(
    parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink   (input valid, input sample, input start_req, output ready);
endinterface

[rtl/swm_out_if.sv]
interface swm_out_if #(
    parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

[rtl/sliding_window_maximum_unit.sv]
// An accepted word goes straight to S_APPEND and then S_OUT when the queue is empty or cleared;
// otherwise it first steps through the queue, evicting candidates aged out of the window
// and discarding those that are not larger than the new sample.
// A new word is accepted only in S_IDLE, once the last one is through; every queue step is a registered memory
// read and a compare; a result held in the output register stalls the unit in S_OUT.
// Reset (synchronous, active low) empties the queue, clears the warm-up count and sets
// window_size to 1; the candidate memory itself is not cleared.
module sliding_window_maximum_unit #(
    parameter int unsigned WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [swm_pkg::CFG_W-1:0] i_cfg_data,
    swm_in_if.sink                   i_in,
    swm_out_if.source                o_out
);

    localparam int unsigned PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int unsigned DEPTH = 2 ** PTR_W;
    localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int unsigned TS_W  = PTR_W + 1;
    localparam int unsigned CMP_W = (CNT_W > swm_pkg::CFG_W) ? CNT_W : swm_pkg::CFG_W;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] value;
        logic [TS_W-1:0]         stamp;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EV_RD,
        S_EV_CHK,
        S_DS_RD,
        S_DS_CHK,
        S_APPEND,
        S_OUT
    } t_state;

    t_state                   r_state;
    logic [swm_pkg::CFG_W-1:0] r_window_size;
    logic [PTR_W-1:0]         r_head;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_seen;
    logic [TS_W-1:0]          r_time;
    logic [SAMPLE_WIDTH-1:0]  r_sample;
    logic                     r_app_empty;
    logic                     r_emit;
    logic                     r_out_valid;
    logic [SAMPLE_WIDTH-1:0]  r_out_data;

    t_entry                   r_mem [DEPTH];
    t_entry                   r_rd;

    logic [CMP_W-1:0]         cfg_ext;
    logic [CNT_W-1:0]         win;
    logic [PTR_W-1:0]         back_addr;
    logic [PTR_W-1:0]         tail_addr;
    logic [PTR_W-1:0]         rd_addr;
    logic                     mem_we;
    logic [TS_W-1:0]          age;
    logic [CNT_W-1:0]         n_seen;
    logic                     in_fire;
    logic                     out_load;

    // A window of zero acts as one; anything above the queue depth is clamped.
    always_comb begin
        cfg_ext = CMP_W'(r_window_size);
        if (cfg_ext == '0) begin
            win = CNT_W'(1);
        end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
            win = CNT_W'(WINDOW_MAX);
        end else begin
            win = CNT_W'(cfg_ext);
        end
    end

    assign tail_addr = r_head + PTR_W'(r_count);
    assign back_addr = tail_addr - PTR_W'(1);
    assign rd_addr   = (r_state == S_DS_RD) ? back_addr : r_head;
    assign mem_we    = (r_state == S_APPEND);
    // Ages come from the difference of arrival stamps, modulo the stamp width.
    assign age       = r_time - r_rd.stamp;
    assign n_seen    = (r_seen < win) ? r_seen + CNT_W'(1) : win;

    assign in_fire     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.window_max = r_out_data;

    // A result is loaded when the output register is empty or drains in the same cycle.
    assign out_load = (r_state == S_OUT) && r_emit && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[tail_addr] <= '{value: r_sample, stamp: r_time};
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_window_size <= swm_pkg::CFG_W'(1);
            r_head        <= '0;
            r_count       <= '0;
            r_seen        <= '0;
            r_time        <= '0;
            r_app_empty   <= 1'b0;
            r_emit        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window_size <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_app_empty ? r_sample : r_rd.value;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_sample <= i_in.sample;
                        r_time   <= r_time + TS_W'(1);
                        if (i_in.start_req) begin
                            r_count <= '0;
                            r_seen  <= '0;
                            r_state <= S_APPEND;
                        end else if (r_count == '0) begin
                            r_state <= S_APPEND;
                        end else begin
                            r_state <= S_EV_RD;
                        end
                    end
                end
                S_EV_RD: begin
                    r_state <= S_EV_CHK;
                end
                S_EV_CHK: begin
                    if (age >= TS_W'(win)) begin
                        r_head  <= r_head + PTR_W'(1);
                        r_count <= r_count - CNT_W'(1);
                        r_state <= (r_count == CNT_W'(1)) ? S_APPEND : S_EV_RD;
                    end else begin
                        r_state <= S_DS_RD;
                    end
                end
                S_DS_RD: begin
                    r_state <= S_DS_CHK;
                end
                S_DS_CHK: begin
                    if ($signed(r_rd.value) <= $signed(r_sample)) begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= (r_count == CNT_W'(1)) ? S_APPEND : S_DS_RD;
                    end else begin
                        r_state <= S_APPEND;
                    end
                end
                S_APPEND: begin
                    // The head is read in this cycle; when the queue was empty the new
                    // word itself becomes the front.
                    r_app_empty <= (r_count == '0);
                    r_count     <= r_count + CNT_W'(1);
                    r_seen      <= n_seen;
                    r_emit      <= (n_seen >= win);
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!r_emit || out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW_MAX))
        else $error("candidate count exceeds queue depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("unit idle right after accepting a word");

    a_check_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV_CHK || r_state == S_DS_CHK) |-> (r_count != '0))
        else $error("queue step on an empty queue");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("pending result lost or changed");
`endif

endmodule
